// File: rtl/kab_pkg.sv
package kab_pkg;

   // two axes, fixed by the x and y payload fields
   localparam int AXES = 2;

   localparam int CFG_W       = 24;
   localparam int CSR_INDEX_W = 2;

   localparam int ACCEL_W = 25;
   localparam int RATE_W  = 29;
   localparam int ANGLE_W = 32;

   localparam int COV_FRAC_BITS_DEFAULT = 24;

   // shared multiplier: 33 x 33 signed, 66-bit product
   localparam int OPND_W = 33;
   localparam int PROD_W = 2 * OPND_W;
   // wide accumulator for sums ahead of saturation
   localparam int ACC_W  = 48;

   localparam logic [CFG_W-1:0] PERIOD_DT_RESET     = 24'd335544;
   localparam logic [CFG_W-1:0] ANGLE_NOISE_RESET   = 24'd167772;
   localparam logic [CFG_W-1:0] BIAS_NOISE_RESET    = 24'd5033;
   localparam logic [CFG_W-1:0] MEASURE_NOISE_RESET = 24'd167772;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PERIOD_DT     = 2'd0,
      CSR_ANGLE_NOISE   = 2'd1,
      CSR_BIAS_NOISE    = 2'd2,
      CSR_MEASURE_NOISE = 2'd3
   } csr_index_type;

   function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] max_v;
      logic signed [ACC_W-1:0] min_v;
      max_v = ACC_W'(32'sh7FFF_FFFF);
      min_v = ACC_W'(-33'sd2147483648);
      if (v > max_v) begin
         return 32'sh7FFF_FFFF;
      end else if (v < min_v) begin
         return 32'sh8000_0000;
      end
      return ANGLE_W'(v);
   endfunction

   // floor((v + 2^(s-1)) / 2^s), called with constant shift amounts
   function automatic logic signed [ACC_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] v,
      input int unsigned              s
   );
      logic signed [PROD_W:0] w;
      w = (PROD_W+1)'(v) + ((PROD_W+1)'(1) <<< (s - 1));
      return ACC_W'(w >>> s);
   endfunction

endpackage

// File: rtl/kalman_angle_bias_filter.sv
// Two-axis angle and gyro bias Kalman filter. Each request transaction carries an accelerometer
// angle (Q9.16) and a gyro rate (Q13.16) per axis; each produces one response transaction with
// the two filtered angles (Q16.16, saturated). Filter state and covariance live in the block
// and clear on reset. The axes run one after the other through a single 33x33 multiplier
// (operand, product and write-back steps for each of 11 products per axis) and a restoring
// divider that yields one gain bit per cycle for each of the two gains per axis. Both gain
// divisions are skipped when the innovation variance is not positive, and a gain's bit loop
// when that gain saturates. req_ready is high only while idle; a finished response waits in
// its own register so the next request can be accepted. Configuration registers (period,
// angle noise, bias noise, measurement noise, all unsigned Q0.24) are written through the csr
// channel while the block is idle.
module kalman_angle_bias_filter #(
   parameter int COVARIANCE_FRACTION_BITS = kab_pkg::COV_FRAC_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [kab_pkg::ACCEL_W-1:0]      req_accel_angle_x,
   input  logic signed [kab_pkg::RATE_W-1:0]       req_gyro_rate_x,
   input  logic signed [kab_pkg::ACCEL_W-1:0]      req_accel_angle_y,
   input  logic signed [kab_pkg::RATE_W-1:0]       req_gyro_rate_y,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [kab_pkg::ANGLE_W-1:0]      rsp_filtered_angle_x,
   output logic signed [kab_pkg::ANGLE_W-1:0]      rsp_filtered_angle_y,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [kab_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [kab_pkg::CFG_W-1:0]               csr_data
);

   localparam int F          = COVARIANCE_FRACTION_BITS;
   localparam int AXES       = kab_pkg::AXES;
   localparam int AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int CFG_W      = kab_pkg::CFG_W;
   localparam int ANGLE_W    = kab_pkg::ANGLE_W;
   localparam int OPND_W     = kab_pkg::OPND_W;
   localparam int PROD_W     = kab_pkg::PROD_W;
   localparam int ACC_W      = kab_pkg::ACC_W;
   localparam int NOISE_SHFT = 2 * CFG_W - F;
   localparam int MAG_W      = ANGLE_W + F;
   localparam int RW         = CFG_W + F + 1;
   localparam int DEN_W      = 33;
   localparam int CNT_W      = $clog2(ANGLE_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_OP,
      ST_MUL,
      ST_MUL_WB,
      ST_GAIN,
      ST_DIV_INIT,
      ST_DIV_ITER,
      ST_DIV_DONE,
      ST_AXIS_END,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      MUL_ANG_PRED,
      MUL_P00_DT,
      MUL_P00_Q,
      MUL_P01_DT,
      MUL_P11_Q,
      MUL_ANG_UPD,
      MUL_BIAS_UPD,
      MUL_P00_UPD,
      MUL_P01_UPD,
      MUL_P10_UPD,
      MUL_P11_UPD
   } mul_type;

   state_type state_ff;
   mul_type   mul_ff;
   logic [AXIS_W-1:0] axis_ff;

   logic [CFG_W-1:0] dt_ff;
   logic [CFG_W-1:0] qa_ff;
   logic [CFG_W-1:0] qg_ff;
   logic [CFG_W-1:0] mn_ff;

   logic signed [kab_pkg::ACCEL_W-1:0] acc_ff  [AXES];
   logic signed [kab_pkg::RATE_W-1:0]  rate_ff [AXES];

   // filter state per axis
   logic signed [ANGLE_W-1:0] ang_ff  [AXES];
   logic signed [ANGLE_W-1:0] bias_ff [AXES];
   logic signed [ANGLE_W-1:0] p00_ff  [AXES];
   logic signed [ANGLE_W-1:0] p01_ff  [AXES];
   logic signed [ANGLE_W-1:0] p10_ff  [AXES];
   logic signed [ANGLE_W-1:0] p11_ff  [AXES];

   // working copy of the axis being processed (predicted values)
   logic signed [ANGLE_W-1:0] w_ang_ff;
   logic signed [ANGLE_W-1:0] w_bias_ff;
   logic signed [ANGLE_W-1:0] w_p00_ff;
   logic signed [ANGLE_W-1:0] w_p01_ff;
   logic signed [ANGLE_W-1:0] w_p10_ff;
   logic signed [ANGLE_W-1:0] w_p11_ff;
   logic signed [ACC_W-1:0]   t00_ff;

   logic signed [ANGLE_W-1:0] y_ff;
   logic signed [ANGLE_W-1:0] k0_ff;
   logic signed [ANGLE_W-1:0] k1_ff;

   logic signed [OPND_W-1:0] op_a_ff;
   logic signed [OPND_W-1:0] op_b_ff;
   logic signed [PROD_W-1:0] prod_ff;

   // divider
   logic [DEN_W-1:0]   s_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [ANGLE_W-1:0] low_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               neg_ff;
   logic               div_k1_ff;

   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_ang_ff [AXES];

   logic signed [OPND_W-1:0] op_a_in;
   logic signed [OPND_W-1:0] op_b_in;
   logic signed [ACC_W-1:0]  rnd_cfg;
   logic signed [ACC_W-1:0]  rnd_noise;
   logic signed [ACC_W-1:0]  rnd_frac;
   logic [RW-1:0]            r_full;
   logic [DEN_W-1:0]         r_val;
   logic signed [DEN_W:0]    s_in;
   logic signed [ANGLE_W-1:0] y_in;
   logic signed [ANGLE_W-1:0] num;
   logic [ANGLE_W-1:0]       mag32;
   logic [MAG_W-1:0]         mag;
   logic [F-1:0]             mag_hi;
   logic                     div_ovf;
   logic signed [ANGLE_W-1:0] ovf_gain_in;
   logic [DEN_W:0]           trial;
   logic                     trial_ge;
   logic [DEN_W-1:0]         rem_in;
   logic signed [ANGLE_W-1:0] quot_gain_in;
   logic                     last_axis;
   logic                     rsp_free;

   assign req_ready            = (state_ff == ST_IDLE);
   assign csr_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_filtered_angle_x = rsp_ang_ff[0];
   assign rsp_filtered_angle_y = rsp_ang_ff[1];

   assign last_axis = (axis_ff == AXIS_W'(AXES - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // operand selection for the shared multiplier
   always_comb begin
      op_a_in = '0;
      op_b_in = '0;
      unique case (mul_ff)
         MUL_ANG_PRED: begin
            op_a_in = $signed({9'b0, dt_ff});
            op_b_in = OPND_W'(rate_ff[axis_ff]) - OPND_W'(w_bias_ff);
         end
         MUL_P00_DT: begin
            op_a_in = $signed({9'b0, dt_ff});
            op_b_in = OPND_W'(w_p01_ff) + OPND_W'(w_p10_ff);
         end
         MUL_P00_Q: begin
            op_a_in = $signed({9'b0, qa_ff});
            op_b_in = $signed({9'b0, dt_ff});
         end
         MUL_P01_DT: begin
            op_a_in = $signed({9'b0, dt_ff});
            op_b_in = OPND_W'(w_p11_ff);
         end
         MUL_P11_Q: begin
            op_a_in = $signed({9'b0, qg_ff});
            op_b_in = $signed({9'b0, dt_ff});
         end
         MUL_ANG_UPD: begin
            op_a_in = OPND_W'(k0_ff);
            op_b_in = OPND_W'(y_ff);
         end
         MUL_BIAS_UPD: begin
            op_a_in = OPND_W'(k1_ff);
            op_b_in = OPND_W'(y_ff);
         end
         MUL_P00_UPD: begin
            op_a_in = OPND_W'(k0_ff);
            op_b_in = OPND_W'(w_p00_ff);
         end
         MUL_P01_UPD: begin
            op_a_in = OPND_W'(k0_ff);
            op_b_in = OPND_W'(w_p01_ff);
         end
         MUL_P10_UPD: begin
            op_a_in = OPND_W'(k1_ff);
            op_b_in = OPND_W'(w_p00_ff);
         end
         MUL_P11_UPD: begin
            op_a_in = OPND_W'(k1_ff);
            op_b_in = OPND_W'(w_p01_ff);
         end
         default: begin
            op_a_in = '0;
            op_b_in = '0;
         end
      endcase
   end

   assign rnd_cfg   = kab_pkg::round_shift(prod_ff, CFG_W);
   assign rnd_noise = kab_pkg::round_shift(prod_ff, NOISE_SHFT);
   assign rnd_frac  = kab_pkg::round_shift(prod_ff, F);

   // measurement noise rescaled to the covariance format
   assign r_full = (RW'(mn_ff) << F) + RW'(1 << (CFG_W - 1));
   assign r_val  = DEN_W'(r_full >> CFG_W);
   assign s_in   = (DEN_W+1)'(w_p00_ff) + $signed({1'b0, r_val});
   assign y_in   = kab_pkg::sat32(ACC_W'(acc_ff[axis_ff]) - ACC_W'(w_ang_ff));

   // divider setup: |num| * 2^F / s, quotient of 32 bits or saturation
   assign num    = div_k1_ff ? w_p10_ff : w_p00_ff;
   assign mag32  = num[ANGLE_W-1] ? ANGLE_W'(-num) : ANGLE_W'(num);
   assign mag    = {mag32, {F{1'b0}}};
   assign mag_hi = mag[MAG_W-1:ANGLE_W];
   assign div_ovf = ((DEN_W+1)'(mag_hi) >= (DEN_W+1)'(s_ff));
   assign ovf_gain_in = num[ANGLE_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;

   assign trial    = {rem_ff, low_ff[ANGLE_W-1]};
   assign trial_ge = (trial >= {1'b0, s_ff});
   assign rem_in   = trial_ge ? DEN_W'(trial - {1'b0, s_ff}) : trial[DEN_W-1:0];

   always_comb begin
      if (neg_ff) begin
         if (low_ff > 32'h8000_0000) begin
            quot_gain_in = 32'sh8000_0000;
         end else begin
            quot_gain_in = $signed(32'd0 - low_ff);
         end
      end else if (low_ff[ANGLE_W-1]) begin
         quot_gain_in = 32'sh7FFF_FFFF;
      end else begin
         quot_gain_in = $signed(low_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_ff       <= MUL_ANG_PRED;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_k1_ff    <= 1'b0;
         dt_ff        <= kab_pkg::PERIOD_DT_RESET;
         qa_ff        <= kab_pkg::ANGLE_NOISE_RESET;
         qg_ff        <= kab_pkg::BIAS_NOISE_RESET;
         mn_ff        <= kab_pkg::MEASURE_NOISE_RESET;
         for (int i = 0; i < AXES; i++) begin
            ang_ff[i]  <= '0;
            bias_ff[i] <= '0;
            p00_ff[i]  <= '0;
            p01_ff[i]  <= '0;
            p10_ff[i]  <= '0;
            p11_ff[i]  <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (kab_pkg::csr_index_type'(csr_index))
               kab_pkg::CSR_PERIOD_DT:     dt_ff <= csr_data;
               kab_pkg::CSR_ANGLE_NOISE:   qa_ff <= csr_data;
               kab_pkg::CSR_BIAS_NOISE:    qg_ff <= csr_data;
               kab_pkg::CSR_MEASURE_NOISE: mn_ff <= csr_data;
               default: ;
            endcase
         end

         // in ST_DONE the hand-off below decides the next valid
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  acc_ff[0]  <= req_accel_angle_x;
                  rate_ff[0] <= req_gyro_rate_x;
                  acc_ff[1]  <= req_accel_angle_y;
                  rate_ff[1] <= req_gyro_rate_y;
                  axis_ff    <= '0;
                  state_ff   <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               w_ang_ff  <= ang_ff[axis_ff];
               w_bias_ff <= bias_ff[axis_ff];
               w_p00_ff  <= p00_ff[axis_ff];
               w_p01_ff  <= p01_ff[axis_ff];
               w_p10_ff  <= p10_ff[axis_ff];
               w_p11_ff  <= p11_ff[axis_ff];
               mul_ff    <= MUL_ANG_PRED;
               state_ff  <= ST_MUL_OP;
            end
            ST_MUL_OP: begin
               op_a_ff  <= op_a_in;
               op_b_ff  <= op_b_in;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= op_a_ff * op_b_ff;
               state_ff <= ST_MUL_WB;
            end
            ST_MUL_WB: begin
               unique case (mul_ff)
                  MUL_ANG_PRED: w_ang_ff <= kab_pkg::sat32(ACC_W'(w_ang_ff) + rnd_cfg);
                  MUL_P00_DT:   t00_ff   <= ACC_W'(w_p00_ff) - rnd_cfg;
                  MUL_P00_Q:    w_p00_ff <= kab_pkg::sat32(t00_ff + rnd_noise);
                  MUL_P01_DT: begin
                     w_p01_ff <= kab_pkg::sat32(ACC_W'(w_p01_ff) - rnd_cfg);
                     w_p10_ff <= kab_pkg::sat32(ACC_W'(w_p10_ff) - rnd_cfg);
                  end
                  MUL_P11_Q:    w_p11_ff <= kab_pkg::sat32(ACC_W'(w_p11_ff) + rnd_noise);
                  MUL_ANG_UPD:  w_ang_ff <= kab_pkg::sat32(ACC_W'(w_ang_ff) + rnd_frac);
                  MUL_BIAS_UPD: w_bias_ff <= kab_pkg::sat32(ACC_W'(w_bias_ff) + rnd_frac);
                  // covariance update writes back, keeping predicted p00 and p01 for later
                  MUL_P00_UPD:
                     p00_ff[axis_ff] <= kab_pkg::sat32(ACC_W'(w_p00_ff) - rnd_frac);
                  MUL_P01_UPD:
                     p01_ff[axis_ff] <= kab_pkg::sat32(ACC_W'(w_p01_ff) - rnd_frac);
                  MUL_P10_UPD:
                     p10_ff[axis_ff] <= kab_pkg::sat32(ACC_W'(w_p10_ff) - rnd_frac);
                  MUL_P11_UPD:
                     p11_ff[axis_ff] <= kab_pkg::sat32(ACC_W'(w_p11_ff) - rnd_frac);
                  default: ;
               endcase
               priority if (mul_ff == MUL_P11_Q) begin
                  state_ff <= ST_GAIN;
               end else if (mul_ff == MUL_P11_UPD) begin
                  state_ff <= ST_AXIS_END;
               end else begin
                  mul_ff   <= mul_type'(4'(mul_ff) + 4'd1);
                  state_ff <= ST_MUL_OP;
               end
            end
            ST_GAIN: begin
               y_ff <= y_in;
               if (!s_in[DEN_W] && (s_in != '0)) begin
                  s_ff      <= s_in[DEN_W-1:0];
                  div_k1_ff <= 1'b0;
                  state_ff  <= ST_DIV_INIT;
               end else begin
                  // innovation variance not positive: no correction
                  k0_ff    <= '0;
                  k1_ff    <= '0;
                  mul_ff   <= MUL_ANG_UPD;
                  state_ff <= ST_MUL_OP;
               end
            end
            ST_DIV_INIT: begin
               neg_ff <= num[ANGLE_W-1];
               if (div_ovf) begin
                  if (div_k1_ff) begin
                     k1_ff    <= ovf_gain_in;
                     mul_ff   <= MUL_ANG_UPD;
                     state_ff <= ST_MUL_OP;
                  end else begin
                     k0_ff     <= ovf_gain_in;
                     div_k1_ff <= 1'b1;
                     state_ff  <= ST_DIV_INIT;
                  end
               end else begin
                  rem_ff   <= DEN_W'(mag_hi);
                  low_ff   <= mag[ANGLE_W-1:0];
                  cnt_ff   <= CNT_W'(ANGLE_W - 1);
                  state_ff <= ST_DIV_ITER;
               end
            end
            ST_DIV_ITER: begin
               rem_ff <= rem_in;
               low_ff <= {low_ff[ANGLE_W-2:0], trial_ge};
               if (cnt_ff == '0) begin
                  state_ff <= ST_DIV_DONE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_DIV_DONE: begin
               if (div_k1_ff) begin
                  k1_ff    <= quot_gain_in;
                  mul_ff   <= MUL_ANG_UPD;
                  state_ff <= ST_MUL_OP;
               end else begin
                  k0_ff     <= quot_gain_in;
                  div_k1_ff <= 1'b1;
                  state_ff  <= ST_DIV_INIT;
               end
            end
            ST_AXIS_END: begin
               ang_ff[axis_ff]  <= w_ang_ff;
               bias_ff[axis_ff] <= w_bias_ff;
               if (last_axis) begin
                  state_ff <= ST_DONE;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  for (int i = 0; i < AXES; i++) begin
                     rsp_ang_ff[i] <= ang_ff[i];
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: verif/tb_kalman_angle_bias_filter.sv
`timescale 1ns / 1ps

module tb_kalman_angle_bias_filter;

   localparam int     AXES           = kab_pkg::AXES;
   localparam int     ACCEL_W        = kab_pkg::ACCEL_W;
   localparam int     RATE_W         = kab_pkg::RATE_W;
   localparam int     ANGLE_W        = kab_pkg::ANGLE_W;
   localparam int     CFG_W          = kab_pkg::CFG_W;
   localparam longint ACCEL_LIM      = 64'sd11796480;
   localparam longint RATE_LIM       = 64'sd157286400;
   localparam int     COV_F          = kab_pkg::COV_FRAC_BITS_DEFAULT;
   localparam int     SETTING_PHASES = 10;
   localparam int     RANDOM_PER_PHASE = 158;
   localparam int     LONG_HOLD      = 1500;
   localparam int     WATCHDOG_LIMIT = 6000;
   localparam logic [CFG_W-1:0] CFG_MAX = 24'hFF_FFFF;

   typedef struct {
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [RATE_W-1:0]  rate_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [RATE_W-1:0]  rate_y;
   } imu_sample_type;

   typedef struct {
      logic signed [ANGLE_W-1:0] x;
      logic signed [ANGLE_W-1:0] y;
   } angle_pair_type;

   class filter_scoreboard;
      longint         period;
      longint         q_angle;
      longint         q_bias;
      longint         r_meas;
      longint         angle_st[AXES];
      longint         bias_st[AXES];
      longint         cov_st[AXES][4];
      angle_pair_type expected_angles[$];
      int unsigned    mismatches;
      int unsigned    samples_in;
      int unsigned    results_checked;
      int unsigned    reg_writes;
      int unsigned    gain_skips;
      int unsigned    clamped_outputs;

      function new();
         period  = kab_pkg::PERIOD_DT_RESET;
         q_angle = kab_pkg::ANGLE_NOISE_RESET;
         q_bias  = kab_pkg::BIAS_NOISE_RESET;
         r_meas  = kab_pkg::MEASURE_NOISE_RESET;
         foreach (angle_st[a]) begin
            angle_st[a] = 0;
            bias_st[a]  = 0;
            for (int i = 0; i < 4; i++) cov_st[a][i] = 0;
         end
         mismatches      = 0;
         samples_in      = 0;
         results_checked = 0;
         reg_writes      = 0;
         gain_skips      = 0;
         clamped_outputs = 0;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // round half up, then floor
      function longint scale_down(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function void write_reg(kab_pkg::csr_index_type idx, logic [CFG_W-1:0] v);
         reg_writes++;
         case (idx)
            kab_pkg::CSR_PERIOD_DT:     period  = v;
            kab_pkg::CSR_ANGLE_NOISE:   q_angle = v;
            kab_pkg::CSR_BIAS_NOISE:    q_bias  = v;
            kab_pkg::CSR_MEASURE_NOISE: r_meas  = v;
            default: ;
         endcase
      endfunction

      function longint filter_axis(int a, longint acc, longint rate);
         longint ang, bias, p00, p01, p10, p11, y, s, k0, k1, r;
         r    = scale_down(r_meas * (64'sd1 <<< COV_F), CFG_W);
         ang  = angle_st[a];
         bias = bias_st[a];
         k0   = 0;
         k1   = 0;
         // predict
         ang = clamp32(ang + scale_down(period * (rate - bias), CFG_W));
         p00 = cov_st[a][0];
         p01 = cov_st[a][1];
         p10 = cov_st[a][2];
         p11 = cov_st[a][3];
         p00 = clamp32(p00 - scale_down(period * (p01 + p10), CFG_W)
                       + scale_down(q_angle * period, 2 * CFG_W - COV_F));
         p01 = clamp32(p01 - scale_down(period * p11, CFG_W));
         p10 = clamp32(p10 - scale_down(period * p11, CFG_W));
         p11 = clamp32(p11 + scale_down(q_bias * period, 2 * CFG_W - COV_F));
         // correct toward the accelerometer angle
         y = clamp32(acc - ang);
         s = p00 + r;
         if (s > 0) begin
            k0 = clamp32((p00 * (64'sd1 <<< COV_F)) / s);
            k1 = clamp32((p10 * (64'sd1 <<< COV_F)) / s);
         end else begin
            gain_skips++;
         end
         ang  = clamp32(ang + scale_down(k0 * y, COV_F));
         bias = clamp32(bias + scale_down(k1 * y, COV_F));
         // pre-update p00 and p01 on the right-hand side
         cov_st[a][0] = clamp32(p00 - scale_down(k0 * p00, COV_F));
         cov_st[a][1] = clamp32(p01 - scale_down(k0 * p01, COV_F));
         cov_st[a][2] = clamp32(p10 - scale_down(k1 * p00, COV_F));
         cov_st[a][3] = clamp32(p11 - scale_down(k1 * p01, COV_F));
         angle_st[a] = ang;
         bias_st[a]  = bias;
         return ang;
      endfunction

      function void note_input(logic signed [ACCEL_W-1:0] ax, logic signed [RATE_W-1:0] rx,
                               logic signed [ACCEL_W-1:0] ay, logic signed [RATE_W-1:0] ry);
         angle_pair_type e;
         samples_in++;
         e.x = ANGLE_W'(filter_axis(0, longint'(ax), longint'(rx)));
         e.y = ANGLE_W'(filter_axis(1, longint'(ay), longint'(ry)));
         expected_angles.push_back(e);
      endfunction

      function void check_result(logic signed [ANGLE_W-1:0] x, logic signed [ANGLE_W-1:0] y);
         angle_pair_type e;
         if (expected_angles.size() == 0) begin
            $error("response transaction with nothing pending: x %0d y %0d", x, y);
            mismatches++;
            return;
         end
         e = expected_angles.pop_front();
         results_checked++;
         if (x != e.x) begin
            $error("filtered_angle_x: expected %0d, actual %0d", e.x, x);
            mismatches++;
         end
         if (y != e.y) begin
            $error("filtered_angle_y: expected %0d, actual %0d", e.y, y);
            mismatches++;
         end
         if (e.x == 32'sh7FFF_FFFF || e.x == 32'sh8000_0000) clamped_outputs++;
         if (e.y == 32'sh7FFF_FFFF || e.y == 32'sh8000_0000) clamped_outputs++;
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [ACCEL_W-1:0] req_accel_angle_x = '0;
   logic signed [RATE_W-1:0]  req_gyro_rate_x = '0;
   logic signed [ACCEL_W-1:0] req_accel_angle_y = '0;
   logic signed [RATE_W-1:0]  req_gyro_rate_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [ANGLE_W-1:0] rsp_filtered_angle_x;
   logic signed [ANGLE_W-1:0] rsp_filtered_angle_y;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   kab_pkg::csr_index_type    csr_index = kab_pkg::CSR_PERIOD_DT;
   logic [CFG_W-1:0]          csr_data = '0;

   filter_scoreboard sb = new();
   longint           walk_angle[2] = '{0, 0};
   int unsigned      samples_offered = 0;
   int unsigned      settings_used = 1;
   int unsigned      quiet_cycles = 0;

   kalman_angle_bias_filter #(
      .COVARIANCE_FRACTION_BITS(COV_F)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_accel_angle_x    (req_accel_angle_x),
      .req_gyro_rate_x      (req_gyro_rate_x),
      .req_accel_angle_y    (req_accel_angle_y),
      .req_gyro_rate_y      (req_gyro_rate_y),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_filtered_angle_x (rsp_filtered_angle_x),
      .rsp_filtered_angle_y (rsp_filtered_angle_y),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) begin
            sb.note_input(req_accel_angle_x, req_gyro_rate_x,
                          req_accel_angle_y, req_gyro_rate_y);
         end
         if (rsp_valid && rsp_ready) sb.check_result(rsp_filtered_angle_x, rsp_filtered_angle_y);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint rand_span(longint lim);
      return longint'($urandom_range(0, 32'(2 * lim))) - lim;
   endfunction

   function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint pick_edge(longint lim);
      case ($urandom_range(0, 5))
         0: return -lim;
         1: return lim;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return lim - 1;
      endcase
   endfunction

   function automatic imu_sample_type make_sample(longint ax, longint rx, longint ay,
                                                  longint ry);
      imu_sample_type smp;
      smp.accel_x = ACCEL_W'(ax);
      smp.rate_x  = RATE_W'(rx);
      smp.accel_y = ACCEL_W'(ay);
      smp.rate_y  = RATE_W'(ry);
      return smp;
   endfunction

   function automatic imu_sample_type directed_sample(int k);
      case (k)
         0:  return make_sample(0, 0, 0, 0);
         1:  return make_sample(ACCEL_LIM, 0, -ACCEL_LIM, 0);
         2:  return make_sample(-ACCEL_LIM, 0, ACCEL_LIM, 0);
         3:  return make_sample(0, RATE_LIM, 0, -RATE_LIM);
         4:  return make_sample(0, -RATE_LIM, 0, RATE_LIM);
         5:  return make_sample(ACCEL_LIM, RATE_LIM, ACCEL_LIM, RATE_LIM);
         6:  return make_sample(-ACCEL_LIM, -RATE_LIM, -ACCEL_LIM, -RATE_LIM);
         7:  return make_sample(ACCEL_LIM, -RATE_LIM, -ACCEL_LIM, RATE_LIM);
         8:  return make_sample(1, -1, -1, 1);
         9:  return make_sample(-1, 1, 1, -1);
         10: return make_sample(ACCEL_LIM - 1, RATE_LIM - 1, -ACCEL_LIM + 1, -RATE_LIM + 1);
         // steady tilt so the filter settles
         default: return make_sample(45 <<< 16, 0, -(30 <<< 16), 0);
      endcase
   endfunction

   function automatic imu_sample_type random_sample();
      longint acc[2];
      longint rate[2];
      longint step;
      int     pick;
      pick = $urandom_range(0, 99);
      for (int a = 0; a < 2; a++) begin
         if (pick < 65) begin
            // slow random walk, rate consistent with the motion
            step          = rand_span(1 <<< 18);
            walk_angle[a] = clip(walk_angle[a] + step, ACCEL_LIM);
            acc[a]        = clip(walk_angle[a] + rand_span(1 <<< 16), ACCEL_LIM);
            rate[a]       = clip(step * 50 + rand_span(1 <<< 17), RATE_LIM);
         end else if (pick < 90) begin
            acc[a]  = rand_span(ACCEL_LIM);
            rate[a] = rand_span(RATE_LIM);
         end else begin
            acc[a]  = pick_edge(ACCEL_LIM);
            rate[a] = pick_edge(RATE_LIM);
         end
      end
      return make_sample(acc[0], rate[0], acc[1], rate[1]);
   endfunction

   task automatic send_sample(input imu_sample_type smp);
      int gap;
      gap = $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_accel_angle_x <= smp.accel_x;
      req_gyro_rate_x   <= smp.rate_x;
      req_accel_angle_y <= smp.accel_y;
      req_gyro_rate_y   <= smp.rate_y;
      do @(posedge clock); while (!req_ready);
      samples_offered++;
   endtask

   // one edge first so the last accepted transaction is already queued
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_angles.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // valid stays high across the four writes
   task automatic write_settings(input logic [CFG_W-1:0] dt, input logic [CFG_W-1:0] qa,
                                 input logic [CFG_W-1:0] qg, input logic [CFG_W-1:0] rm);
      kab_pkg::csr_index_type idx[4];
      logic [CFG_W-1:0]       val[4];
      idx = '{kab_pkg::CSR_PERIOD_DT, kab_pkg::CSR_ANGLE_NOISE, kab_pkg::CSR_BIAS_NOISE,
              kab_pkg::CSR_MEASURE_NOISE};
      val = '{dt, qa, qg, rm};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin : receiver
      int gap;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && sb.results_checked >= 400) begin
            // long back-pressure while the sender keeps offering
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings first: edges, signs, then a steady tilt
      for (int k = 0; k < 16; k++) send_sample(directed_sample(k));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_sample(random_sample());

      for (int ph = 1; ph < SETTING_PHASES; ph++) begin
         drain_results();
         case (ph)
            1: write_settings(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
            // zero period and noise; innovation variance goes to zero
            2: write_settings('0, '0, '0, '0);
            3: write_settings(24'd1, CFG_MAX, '0, 24'd1);
            4: write_settings(kab_pkg::PERIOD_DT_RESET, kab_pkg::ANGLE_NOISE_RESET,
                              kab_pkg::BIAS_NOISE_RESET, kab_pkg::MEASURE_NOISE_RESET);
            default: begin
               write_settings(CFG_W'(($urandom_range(0, 3) == 0)
                                     ? $urandom_range(1, CFG_MAX)
                                     : $urandom_range(1 << 14, 1 << 20)),
                              CFG_W'(($urandom_range(0, 1) == 0)
                                     ? $urandom_range(0, CFG_MAX)
                                     : $urandom_range(0, 1 << 20)),
                              CFG_W'(($urandom_range(0, 1) == 0)
                                     ? $urandom_range(0, CFG_MAX)
                                     : $urandom_range(0, 1 << 14)),
                              CFG_W'(($urandom_range(0, 1) == 0)
                                     ? $urandom_range(1, CFG_MAX)
                                     : $urandom_range(1, 1 << 20)));
            end
         endcase
         if (ph == 1) begin
            for (int k = 5; k < 11; k++) send_sample(directed_sample(k));
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) send_sample(random_sample());
      end

      drain_results();
      repeat (300) @(posedge clock);

      $display("tb: %0d imu samples checked over %0d filter settings, %0d register writes",
               sb.results_checked, settings_used, sb.reg_writes);
      $display("tb: %0d axis updates skipped the gain, %0d saturated angle outputs",
               sb.gain_skips, sb.clamped_outputs);
      if (sb.mismatches == 0 && sb.expected_angles.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
